/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of i_clk outside of reset.
`define MCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside of reset.
`define MCR_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* src/mcr_pkg.sv */
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types, codes and defaults of the multichannel convolution block.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Default geometry.
    localparam int DEF_IN_CH  = 6;
    localparam int DEF_OUT_CH = 16;
    localparam int DEF_IN_DIM = 14;
    localparam int DEF_KERNEL = 5;

    // Fixed field widths.
    localparam int DATA_W  = 16;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 12;
    localparam int COORD_W = 4;
    localparam int SHIFT_W = 4;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD_ACT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_WGT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_BIAS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COMPUTE   = 2'd3;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_RELU_ENABLE = 1'b0;
    localparam logic REG_FRAC_SHIFT  = 1'b1;
    localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RST = 4'd8;

    // Store write enables decoded from the item kind.
    typedef struct packed {
        logic act;
        logic wgt;
        logic bias;
    } t_wr_en;

    // Sequencer to datapath control.
    typedef struct packed {
        logic start;   // compute accepted, bias read issued
        logic issue;   // activation and weight read issued
        logic last;    // final read of the window
    } t_mac_ctl;

endpackage

/* src/mcr_if.sv */
// ----------------------------------------------------------------------------
// mcr_if
// Valid/ready channels for input items and convolution results.
// ----------------------------------------------------------------------------
interface mcr_in_if import mcr_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [ADDR_W-1:0]         addr;
    logic signed [DATA_W-1:0]  value;
    logic [COORD_W-1:0]        out_channel;
    logic [COORD_W-1:0]        out_row;
    logic [COORD_W-1:0]        out_col;

    modport source (output valid, kind, addr, value, out_channel, out_row, out_col,
                    input ready);
    modport sink   (input valid, kind, addr, value, out_channel, out_row, out_col,
                    output ready);
endinterface

interface mcr_out_if import mcr_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  conv_value;

    modport source (output valid, conv_value, input ready);
    modport sink   (input valid, conv_value, output ready);
endinterface

/* src/mcr_store.sv */
// ----------------------------------------------------------------------------
// mcr_store
// Activation, weight and bias memories with registered reads.
// ----------------------------------------------------------------------------
module mcr_store import mcr_pkg::*; #(
    parameter int IN_CH  = DEF_IN_CH,
    parameter int OUT_CH = DEF_OUT_CH,
    parameter int IN_DIM = DEF_IN_DIM,
    parameter int KERNEL = DEF_KERNEL,
    localparam int FEAT_DEPTH = IN_CH * IN_DIM * IN_DIM,
    localparam int WGT_DEPTH  = OUT_CH * IN_CH * KERNEL * KERNEL,
    localparam int FA_W = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1,
    localparam int WA_W = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1,
    localparam int BA_W = (OUT_CH > 1) ? $clog2(OUT_CH) : 1
) (
    input  logic                      i_clk,
    input  t_wr_en                    i_wr,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic signed [DATA_W-1:0]  i_wr_data,
    input  t_mac_ctl                  i_ctl,
    input  logic [FA_W-1:0]           i_faddr,
    input  logic [WA_W-1:0]           i_waddr,
    input  logic [BA_W-1:0]           i_baddr,
    output logic signed [DATA_W-1:0]  o_feat,
    output logic signed [DATA_W-1:0]  o_wgt,
    output logic signed [DATA_W-1:0]  o_bias
);

    logic signed [DATA_W-1:0] r_feat_mem [FEAT_DEPTH];
    logic signed [DATA_W-1:0] r_wgt_mem  [WGT_DEPTH];
    logic signed [DATA_W-1:0] r_bias_mem [OUT_CH];
    logic signed [DATA_W-1:0] r_feat_rd;
    logic signed [DATA_W-1:0] r_wgt_rd;
    logic signed [DATA_W-1:0] r_bias_rd;

    // Writes beyond a store's depth are dropped.
    always_ff @(posedge i_clk) begin
        if (i_wr.act && (i_wr_addr < FEAT_DEPTH)) begin
            r_feat_mem[FA_W'(i_wr_addr)] <= i_wr_data;
        end
        if (i_wr.wgt && (i_wr_addr < WGT_DEPTH)) begin
            r_wgt_mem[WA_W'(i_wr_addr)] <= i_wr_data;
        end
        if (i_wr.bias && (i_wr_addr < OUT_CH)) begin
            r_bias_mem[BA_W'(i_wr_addr)] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_feat_rd <= r_feat_mem[i_faddr];
            r_wgt_rd  <= r_wgt_mem[i_waddr];
        end
        if (i_ctl.start) begin
            r_bias_rd <= r_bias_mem[i_baddr];
        end
    end

    assign o_feat = r_feat_rd;
    assign o_wgt  = r_wgt_rd;
    assign o_bias = r_bias_rd;

endmodule

/* src/mcr_seq.sv */
// ----------------------------------------------------------------------------
// mcr_seq
// Walks the kernel window over all input channels and issues store reads.
// ----------------------------------------------------------------------------
module mcr_seq import mcr_pkg::*; #(
    parameter int IN_CH  = DEF_IN_CH,
    parameter int OUT_CH = DEF_OUT_CH,
    parameter int IN_DIM = DEF_IN_DIM,
    parameter int KERNEL = DEF_KERNEL,
    localparam int FEAT_DEPTH = IN_CH * IN_DIM * IN_DIM,
    localparam int WGT_DEPTH  = OUT_CH * IN_CH * KERNEL * KERNEL,
    localparam int FA_W = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1,
    localparam int WA_W = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [COORD_W-1:0]  i_oc,
    input  logic [COORD_W-1:0]  i_orow,
    input  logic [COORD_W-1:0]  i_ocol,
    input  logic                i_done,
    output logic [FA_W-1:0]     o_faddr,
    output logic [WA_W-1:0]     o_waddr,
    output t_mac_ctl            o_ctl,
    output logic                o_busy
);

    localparam int MAC_N = IN_CH * KERNEL * KERNEL;
    localparam int CNT_W = (MAC_N > 1) ? $clog2(MAC_N) : 1;
    localparam int K_W   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
    localparam int STEP_ROW = IN_DIM - KERNEL + 1;
    localparam int STEP_CH  = IN_DIM * IN_DIM - (KERNEL - 1) * IN_DIM - (KERNEL - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [K_W-1:0]   r_kx;
    logic [K_W-1:0]   r_ky;
    logic [FA_W-1:0]  r_faddr;
    logic [WA_W-1:0]  r_waddr;
    logic             run;
    logic             last;

    assign run  = (r_state == ST_RUN);
    assign last = run && (r_cnt == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window addresses advance by constant strides, no per-step multiply.
    always_ff @(posedge i_clk) begin
        if (i_start && (r_state == ST_IDLE)) begin
            r_cnt   <= CNT_W'(MAC_N - 1);
            r_kx    <= '0;
            r_ky    <= '0;
            r_faddr <= FA_W'(i_orow) * FA_W'(IN_DIM) + FA_W'(i_ocol);
            r_waddr <= WA_W'(i_oc) * WA_W'(MAC_N);
        end else if (run) begin
            r_cnt   <= r_cnt - 1'b1;
            r_waddr <= r_waddr + 1'b1;
            if (r_kx == K_W'(KERNEL - 1)) begin
                r_kx <= '0;
                if (r_ky == K_W'(KERNEL - 1)) begin
                    r_ky    <= '0;
                    r_faddr <= r_faddr + FA_W'(STEP_CH);
                end else begin
                    r_ky    <= r_ky + 1'b1;
                    r_faddr <= r_faddr + FA_W'(STEP_ROW);
                end
            end else begin
                r_kx    <= r_kx + 1'b1;
                r_faddr <= r_faddr + 1'b1;
            end
        end
    end

    assign o_faddr     = r_faddr;
    assign o_waddr     = r_waddr;
    assign o_ctl.start = i_start && (r_state == ST_IDLE);
    assign o_ctl.issue = run;
    assign o_ctl.last  = last;
    assign o_busy      = (r_state != ST_IDLE);

endmodule

/* src/mcr_mac.sv */
// ----------------------------------------------------------------------------
// mcr_mac
// Multiply-accumulate datapath with scaling, saturation and rectification.
// ----------------------------------------------------------------------------
module mcr_mac import mcr_pkg::*; #(
    parameter int IN_CH  = DEF_IN_CH,
    parameter int KERNEL = DEF_KERNEL,
    localparam int MAC_N = IN_CH * KERNEL * KERNEL,
    localparam int ACC_W = 2 * DATA_W + $clog2(MAC_N + 1) + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_ctl                  i_ctl,
    input  logic signed [DATA_W-1:0]  i_feat,
    input  logic signed [DATA_W-1:0]  i_wgt,
    input  logic signed [DATA_W-1:0]  i_bias,
    input  logic                      i_relu,
    input  logic [SHIFT_W-1:0]        i_shift,
    input  logic                      i_take,
    output logic                      o_res_vld,
    output logic signed [DATA_W-1:0]  o_res
);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (DATA_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic                         r_init;
    logic                         r_rd_vld;
    logic                         r_rd_last;
    logic                         r_prod_vld;
    logic                         r_prod_last;
    logic                         r_acc_done;
    logic                         r_shf_vld;
    logic                         r_res_vld;
    logic signed [2*DATA_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]      r_acc;
    logic signed [ACC_W-1:0]      r_shf;
    logic signed [DATA_W-1:0]     r_res;
    logic signed [ACC_W-1:0]      bias_ext;
    logic signed [DATA_W-1:0]     sat_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
            r_acc_done  <= 1'b0;
            r_shf_vld   <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            r_init      <= i_ctl.start;
            r_rd_vld    <= i_ctl.issue;
            r_rd_last   <= i_ctl.last;
            r_prod_vld  <= r_rd_vld;
            r_prod_last <= r_rd_vld && r_rd_last;
            r_acc_done  <= r_prod_vld && r_prod_last;
            r_shf_vld   <= r_acc_done;
            if (r_shf_vld) begin
                r_res_vld <= 1'b1;
            end else if (i_take) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    assign bias_ext = ACC_W'(i_bias);

    // The bias is aligned to the product scale before the sum starts.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= i_feat * i_wgt;
        end
        if (r_init) begin
            r_acc <= bias_ext <<< i_shift;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_acc_done) begin
            r_shf <= r_acc >>> i_shift;
        end
        if (r_shf_vld) begin
            r_res <= sat_val;
        end
    end

    always_comb begin
        if (r_shf > SAT_HI) begin
            sat_val = SAT_HI[DATA_W-1:0];
        end else if (r_shf < SAT_LO) begin
            sat_val = SAT_LO[DATA_W-1:0];
        end else begin
            sat_val = r_shf[DATA_W-1:0];
        end
        if (i_relu && sat_val[DATA_W-1]) begin
            sat_val = '0;
        end
    end

    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

endmodule

/* src/multichannel_conv2d_relu.sv */
// A compute transfer's result passes the store read, product, accumulator, shift and result registers.
// Computes are taken one at a time: the next is held off until the last result has moved to the
// output register, and the single shared multiply-accumulate reads one activation/weight pair per cycle.
// Load transfers and ignored computes are taken every cycle while no compute is in progress.
// Reset (i_rst_n, synchronous, active low) clears control state and the configuration registers;
// the stores are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
// multichannel_conv2d_relu
// Multi-channel valid 2D convolution with bias, scaling, saturation and ReLU.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multichannel_conv2d_relu import mcr_pkg::*; #(
    parameter int IN_CH  = DEF_IN_CH,
    parameter int OUT_CH = DEF_OUT_CH,
    parameter int IN_DIM = DEF_IN_DIM,
    parameter int KERNEL = DEF_KERNEL
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mcr_in_if.sink              i_in_ch,
    mcr_out_if.source           o_out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int FEAT_DEPTH = IN_CH * IN_DIM * IN_DIM;
    localparam int WGT_DEPTH  = OUT_CH * IN_CH * KERNEL * KERNEL;
    localparam int FA_W = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int WA_W = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int BA_W = (OUT_CH > 1) ? $clog2(OUT_CH) : 1;
    localparam int OUT_MAX = IN_DIM - KERNEL;

    // Configuration registers.
    logic               r_relu;
    logic [SHIFT_W-1:0] r_shift;
    logic               cfg_wr;

    // Input side.
    logic     in_fire;
    logic     busy;
    logic     start;
    t_wr_en   wr_en;

    // Sequencer, store and datapath connections.
    logic [FA_W-1:0]          faddr;
    logic [WA_W-1:0]          waddr;
    t_mac_ctl                 ctl;
    logic signed [DATA_W-1:0] feat;
    logic signed [DATA_W-1:0] wgt;
    logic signed [DATA_W-1:0] bias;
    logic                     res_vld;
    logic signed [DATA_W-1:0] res;
    logic                     res_take;

    // Output register.
    logic                     r_out_vld;
    logic signed [DATA_W-1:0] r_out_val;

    // The APB write completes in its access cycle; the register index is the
    // word address bit, so every address lands on one of the two registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relu  <= 1'b0;
            r_shift <= FRAC_SHIFT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_RELU_ENABLE) begin
                r_relu <= pwdata[0];
            end else begin
                r_shift <= pwdata[SHIFT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_RELU_ENABLE) begin
            prdata = PDATA_W'(r_relu);
        end else begin
            prdata = PDATA_W'(r_shift);
        end
    end

    // Items are taken whenever no compute is in flight. A finished result
    // may still sit in the output register; loads and the next compute
    // proceed behind it.
    assign i_in_ch.ready = !busy;
    assign in_fire       = i_in_ch.valid && i_in_ch.ready;

    assign wr_en.act  = in_fire && (i_in_ch.kind == KIND_LOAD_ACT);
    assign wr_en.wgt  = in_fire && (i_in_ch.kind == KIND_LOAD_WGT);
    assign wr_en.bias = in_fire && (i_in_ch.kind == KIND_LOAD_BIAS);

    // A compute outside the output map is accepted and dropped.
    assign start = in_fire && (i_in_ch.kind == KIND_COMPUTE)
                && (i_in_ch.out_channel < OUT_CH)
                && (i_in_ch.out_row <= OUT_MAX)
                && (i_in_ch.out_col <= OUT_MAX);

    mcr_seq #(
        .IN_CH  (IN_CH),
        .OUT_CH (OUT_CH),
        .IN_DIM (IN_DIM),
        .KERNEL (KERNEL)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_oc    (i_in_ch.out_channel),
        .i_orow  (i_in_ch.out_row),
        .i_ocol  (i_in_ch.out_col),
        .i_done  (res_take),
        .o_faddr (faddr),
        .o_waddr (waddr),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // The bias read is issued in the acceptance cycle with the item's
    // output channel; the window reads follow one per cycle.
    mcr_store #(
        .IN_CH  (IN_CH),
        .OUT_CH (OUT_CH),
        .IN_DIM (IN_DIM),
        .KERNEL (KERNEL)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_en),
        .i_wr_addr (i_in_ch.addr),
        .i_wr_data (i_in_ch.value),
        .i_ctl     (ctl),
        .i_faddr   (faddr),
        .i_waddr   (waddr),
        .i_baddr   (BA_W'(i_in_ch.out_channel)),
        .o_feat    (feat),
        .o_wgt     (wgt),
        .o_bias    (bias)
    );

    mcr_mac #(
        .IN_CH  (IN_CH),
        .KERNEL (KERNEL)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_feat    (feat),
        .i_wgt     (wgt),
        .i_bias    (bias),
        .i_relu    (r_relu),
        .i_shift   (r_shift),
        .i_take    (res_take),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    // The finished value moves into the output register as soon as that
    // register is empty or its current transfer completes.
    assign res_take = res_vld && (!r_out_vld || o_out_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_val <= res;
        end
    end

    assign o_out_ch.valid      = r_out_vld;
    assign o_out_ch.conv_value = r_out_val;

    // An accepted in-range compute holds off the input until its result moves to the output register.
    `MCR_ASSERT(a_busy_after_start, start |=> !i_in_ch.ready, "input ready after compute start")
    // A result only leaves the datapath while its compute still holds the sequencer.
    `MCR_NEVER(a_take_when_idle, res_take && i_in_ch.ready, "result taken while idle")
    // With rectification on, no negative value is ever presented.
    `MCR_NEVER(a_relu_sign, r_out_vld && r_relu && r_out_val[DATA_W-1], "negative result with relu")

endmodule
